// ===== rtl/core/wpg_pkg.sv =====
package wpg_pkg;

   localparam int GRID_SIDE   = 256;
   localparam int KERNEL_HALF = 64;
   localparam int MAX_PLANES  = 8;
   localparam int MAX_SUPPORT = 15;

   localparam int PLANE_TAPS = KERNEL_HALF * KERNEL_HALF;
   localparam int KT_DEPTH   = PLANE_TAPS * MAX_PLANES;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CELL_W     = $clog2(GRID_CELLS);
   localparam int KT_W       = $clog2(KT_DEPTH);
   localparam int PLANE_W    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int ACC_W      = 48;

   typedef enum logic [1:0] {
      OP_LOAD_TAP     = 2'd0,
      OP_LOAD_SUPPORT = 2'd1,
      OP_GRID         = 2'd2,
      OP_READ_CELL    = 2'd3
   } op_type;

   localparam logic [1:0] CSR_PLANES_IN_USE = 2'd0;
   localparam logic [1:0] CSR_OVERSAMPLE    = 2'd1;
   localparam logic [1:0] CSR_UV_SCALE      = 2'd2;
   localparam logic [1:0] CSR_W_PLANE_SCALE = 2'd3;

   // Clamps a two-bit-wider sum back into the signed accumulator range.
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
      logic signed [ACC_W+1:0] hi;
      logic signed [ACC_W+1:0] lo;
      hi = (ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}});
      lo = -hi - (ACC_W+2)'(1);
      if (v > hi) begin
         sat_acc = hi[ACC_W-1:0];
      end else if (v < lo) begin
         sat_acc = lo[ACC_W-1:0];
      end else begin
         sat_acc = v[ACC_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/wprojection_visibility_gridder_core.sv =====
// W-projection gridder. After reset the grid memory is swept to zero, one cell a cycle,
// with busy high. A gridding item streams the (2S+1)^2 footprint of the chosen w-plane,
// S being that plane's support, through a three-stage read-modify-write of the grid
// memory, one tap per cycle; an item that falls off the grid streams no taps and is
// counted as skipped. Every item gives one result on the rsp_ ports, marked by
// rsp_valid for one cycle; the receiver cannot stall it.
module wprojection_visibility_gridder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_addr,
   input  logic signed [15:0] req_tap_re,
   input  logic signed [15:0] req_tap_im,
   input  logic [3:0]  req_support_value,
   input  logic signed [31:0] req_u_coord,
   input  logic signed [31:0] req_v_coord,
   input  logic signed [31:0] req_w_coord,
   input  logic signed [15:0] req_vis_re,
   input  logic signed [15:0] req_vis_im,
   output logic        rsp_valid,
   output logic signed [47:0] rsp_cell_re,
   output logic signed [47:0] rsp_cell_im,
   output logic signed [47:0] rsp_norm_sum,
   output logic [31:0] rsp_skipped_count,
   output logic        rsp_was_skipped,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import wpg_pkg::*;

   localparam int TI_W   = KT_W + 2;
   localparam int GPOS_W = 22;
   localparam int TSUM_W = 27;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_FINISH, ST_READ, ST_MUL_UV, ST_RND, ST_OFF,
      ST_MUL_W, ST_PLANE, ST_CHECK, ST_TAPS, ST_DRAIN, ST_NORM
   } state_type;

   state_type state_ff;

   logic [3:0]  planes_ff;
   logic [2:0]  osf_ff;
   logic [31:0] uv_scale_ff;
   logic [31:0] w_scale_ff;

   logic [95:0] grid_mem [GRID_CELLS];
   logic [31:0] kern_mem [KT_DEPTH];
   logic [95:0] grid_rd_ff;
   logic [31:0] kern_rd_ff;
   logic [3:0]  support_ff [MAX_PLANES];

   logic [CELL_W-1:0] clear_ff;
   logic        rd_ok_ff;
   logic signed [31:0] u_ff, v_ff, w_ff;
   logic signed [15:0] vr_ff, vi_ff;
   logic        conj_ff, neg_u_ff, neg_v_ff, axis_ff;
   logic [63:0] prod_ff;
   logic [19:0] r_ff;
   logic [43:0] d_ff;
   logic        dneg_ff;
   logic signed [GPOS_W-1:0] gu_ff, gv_ff;
   logic signed [4:0] offu_ff, offv_ff;
   logic [PLANE_W-1:0] plane_ff;
   logic [3:0]  s_ff;
   logic signed [4:0] j_ff, k_ff;
   logic signed [TSUM_W-1:0] tsum_ff;
   logic signed [ACC_W-1:0] norm_ff;
   logic [31:0] skip_ff;

   logic        p1_valid_ff, p1_ti_ok_ff;
   logic [CELL_W-1:0] p1_addr_ff;
   logic        p2_valid_ff;
   logic [CELL_W-1:0] p2_addr_ff;
   logic [95:0] p2_old_ff;
   logic signed [32:0] m_rr_ff, m_ii_ff, m_ir_ff, m_ri_ff;

   logic        rsp_valid_ff, was_skipped_ff;
   logic signed [47:0] cell_re_ff, cell_im_ff, norm_out_ff;
   logic [31:0] skip_out_ff;

   logic accept;
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Effective register values.
   logic [2:0] os_eff;
   logic [3:0] np_m1;
   assign os_eff = (osf_ff == 3'd0) ? 3'd1 : osf_ff;
   always_comb begin
      if (planes_ff == 4'd0) begin
         np_m1 = 4'd0;
      end else if (32'(planes_ff) > 32'(MAX_PLANES)) begin
         np_m1 = 4'(MAX_PLANES - 1);
      end else begin
         np_m1 = planes_ff - 4'd1;
      end
   end

   // Shared 32x32 multiplier for the u, v and w scalings.
   logic [31:0] mul_a, mul_b;
   always_comb begin
      if (state_ff == ST_MUL_W) begin
         mul_a = w_ff[31] ? 32'(-w_ff) : 32'(w_ff);
         mul_b = w_scale_ff;
      end else if (axis_ff) begin
         mul_a = v_ff[31] ? 32'(-v_ff) : 32'(v_ff);
         mul_b = uv_scale_ff;
      end else begin
         mul_a = u_ff[31] ? 32'(-u_ff) : 32'(u_ff);
         mul_b = uv_scale_ff;
      end
   end

   // Rounding of the Q.44 product to a cell and its residual.
   logic [63:0] rnd_sum, rs;
   logic [19:0] r_in;
   logic        lt;
   logic [43:0] d_in;
   logic        neg_axis;
   assign neg_axis = axis_ff ? neg_v_ff : neg_u_ff;
   assign rnd_sum  = prod_ff + (64'd1 << 43);
   assign r_in     = rnd_sum[63:44];
   assign rs       = {r_in, 44'd0};
   assign lt       = rs < prod_ff;
   assign d_in     = lt ? 44'(prod_ff - rs) : 44'(rs - prod_ff);

   // Oversample offset and grid position.
   logic [47:0] od, om_full;
   logic [3:0]  om;
   logic signed [4:0] off_in;
   logic signed [GPOS_W-1:0] rsig, cell_in;
   assign od      = 48'(d_ff) * 48'(os_eff);
   assign om_full = od + (48'd1 << 43);
   assign om      = om_full[47:44];
   assign off_in  = dneg_ff ? -$signed({1'b0, om}) : $signed({1'b0, om});
   assign rsig    = $signed({2'b00, r_ff});
   assign cell_in = (neg_axis ? -rsig : rsig) + GPOS_W'(GRID_SIDE / 2);

   // W-plane: the count of odd squares (shifted to Q.38) not above the scaled w, capped at the planes in use less one.
   logic [PLANE_W:0] plane_cnt;
   always_comb begin
      plane_cnt = '0;
      for (int p = 0; p < MAX_PLANES - 1; p++) begin
         if (p < 32'(np_m1) && ((64'((2 * p + 1) * (2 * p + 1)) << 38) <= prod_ff)) begin
            plane_cnt = plane_cnt + (PLANE_W + 1)'(1);
         end
      end
   end

   // Footprint bounds.
   logic signed [23:0] gu_x, gv_x, s_x, side_x;
   logic off_grid;
   assign gu_x   = gu_ff;
   assign gv_x   = gv_ff;
   assign s_x    = $signed({20'd0, s_ff});
   assign side_x = 24'(GRID_SIDE);
   assign off_grid = (gu_x + s_x >= side_x) || (gu_x - s_x < 24'sd0) ||
                     (gv_x + s_x >= side_x) || (gv_x - s_x < 24'sd0);
   logic [31:0] skip_inc;
   assign skip_inc = (skip_ff == 32'hFFFF_FFFF) ? skip_ff : skip_ff + 32'd1;

   // Tap issue stage: kernel index and cell address of footprint position (j, k).
   logic signed [3:0]  os_s;
   logic signed [9:0]  tu_mul, tv_mul;
   logic signed [10:0] tu, tv;
   logic [10:0] atu, atv;
   logic [TI_W-1:0] ti;
   logic signed [GPOS_W:0] row, col;
   logic [CELL_W-1:0] tap_addr;
   assign os_s   = $signed({1'b0, os_eff});
   assign tu_mul = k_ff * os_s;
   assign tv_mul = j_ff * os_s;
   assign tu     = offu_ff + tu_mul;
   assign tv     = offv_ff + tv_mul;
   assign atu    = tu[10] ? 11'(-tu) : 11'(tu);
   assign atv    = tv[10] ? 11'(-tv) : 11'(tv);
   assign ti     = TI_W'(plane_ff) * TI_W'(PLANE_TAPS) + TI_W'(atv) * TI_W'(KERNEL_HALF) +
                   TI_W'(atu);
   assign row    = gv_ff + j_ff;
   assign col    = gu_ff + k_ff;
   assign tap_addr = CELL_W'(CELL_W'(row) * CELL_W'(GRID_SIDE) + CELL_W'(col));

   // Multiply stage operands; an index past the table reads as zero.
   logic signed [15:0] cr;
   logic signed [16:0] ci;
   assign cr = p1_ti_ok_ff ? $signed(kern_rd_ff[31:16]) : 16'sd0;
   always_comb begin
      ci = p1_ti_ok_ff ? 17'($signed(kern_rd_ff[15:0])) : 17'sd0;
      if (conj_ff) begin
         ci = -ci;
      end
   end

   // Accumulate stage.
   logic signed [ACC_W+1:0] sum_re, sum_im;
   logic signed [ACC_W-1:0] new_re, new_im, norm_in;
   assign sum_re  = (ACC_W+2)'($signed(p2_old_ff[95:48])) + (ACC_W+2)'(m_rr_ff - m_ii_ff);
   assign sum_im  = (ACC_W+2)'($signed(p2_old_ff[47:0])) + (ACC_W+2)'(m_ir_ff + m_ri_ff);
   assign new_re  = sat_acc(sum_re);
   assign new_im  = sat_acc(sum_im);
   assign norm_in = sat_acc((ACC_W+2)'(norm_ff) + (ACC_W+2)'(tsum_ff));

   // Grid memory: one read port, one write port.
   logic [CELL_W-1:0] grid_raddr;
   assign grid_raddr = (state_ff == ST_TAPS) ? tap_addr : req_addr[CELL_W-1:0];
   always_ff @(posedge clock) begin
      grid_rd_ff <= grid_mem[grid_raddr];
      if (state_ff == ST_CLEAR) begin
         grid_mem[clear_ff] <= '0;
      end else if (p2_valid_ff) begin
         grid_mem[p2_addr_ff] <= {new_re, new_im};
      end
   end

   // Kernel memory.
   always_ff @(posedge clock) begin
      kern_rd_ff <= kern_mem[ti[KT_W-1:0]];
      if (accept && req_op == OP_LOAD_TAP && 32'(req_addr) < KT_DEPTH) begin
         kern_mem[req_addr[KT_W-1:0]] <= {req_tap_re, req_tap_im};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == OP_LOAD_SUPPORT && 32'(req_addr) < MAX_PLANES) begin
         support_ff[req_addr[PLANE_W-1:0]] <=
            (32'(req_support_value) > MAX_SUPPORT) ? 4'(MAX_SUPPORT) : req_support_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff   <= 4'd1;
         osf_ff      <= 3'd1;
         uv_scale_ff <= 32'd268435456;
         w_scale_ff  <= 32'd16777216;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLANES_IN_USE: planes_ff   <= csr_wdata[3:0];
            CSR_OVERSAMPLE:    osf_ff      <= csr_wdata[2:0];
            CSR_UV_SCALE:      uv_scale_ff <= csr_wdata;
            CSR_W_PLANE_SCALE: w_scale_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Payload and pipeline data registers.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      p1_addr_ff  <= tap_addr;
      p1_ti_ok_ff <= ti < TI_W'(KT_DEPTH);
      p2_addr_ff  <= p1_addr_ff;
      p2_old_ff   <= grid_rd_ff;
      m_rr_ff <= 33'(vr_ff * cr);
      m_ii_ff <= 33'(vi_ff * ci);
      m_ir_ff <= 33'(vi_ff * cr);
      m_ri_ff <= 33'(vr_ff * ci);
      if (accept) begin
         rd_ok_ff <= 32'(req_addr) < GRID_CELLS;
         u_ff     <= req_u_coord;
         v_ff     <= req_v_coord;
         w_ff     <= req_w_coord;
         vr_ff    <= req_vis_re;
         vi_ff    <= req_vis_im;
         conj_ff  <= req_w_coord > 32'sd0;
         neg_u_ff <= req_u_coord > 32'sd0;
         neg_v_ff <= req_v_coord < 32'sd0;
      end
      if (state_ff == ST_RND) begin
         r_ff    <= r_in;
         d_ff    <= d_in;
         dneg_ff <= lt != neg_axis;
      end
      if (state_ff == ST_OFF) begin
         if (axis_ff) begin
            gv_ff   <= cell_in;
            offv_ff <= off_in;
         end else begin
            gu_ff   <= cell_in;
            offu_ff <= off_in;
         end
      end
      if (state_ff == ST_PLANE) begin
         plane_ff <= PLANE_W'(plane_cnt);
         s_ff     <= support_ff[PLANE_W'(plane_cnt)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_ff       <= '0;
         axis_ff        <= 1'b0;
         j_ff           <= '0;
         k_ff           <= '0;
         tsum_ff        <= '0;
         norm_ff        <= '0;
         skip_ff        <= '0;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         was_skipped_ff <= 1'b0;
         cell_re_ff     <= '0;
         cell_im_ff     <= '0;
         norm_out_ff    <= '0;
         skip_out_ff    <= '0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_FINISH) || (state_ff == ST_READ) ||
                         (state_ff == ST_NORM) || (state_ff == ST_CHECK && off_grid);
         p1_valid_ff  <= (state_ff == ST_TAPS);
         p2_valid_ff  <= p1_valid_ff;
         if (p1_valid_ff) begin
            tsum_ff <= tsum_ff + TSUM_W'(cr);
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_ff <= clear_ff + CELL_W'(1);
               if (clear_ff == CELL_W'(GRID_CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  axis_ff <= 1'b0;
                  priority if (req_op == OP_GRID) begin
                     state_ff <= ST_MUL_UV;
                  end else if (req_op == OP_READ_CELL) begin
                     state_ff <= ST_READ;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               cell_re_ff     <= '0;
               cell_im_ff     <= '0;
               norm_out_ff    <= norm_ff;
               skip_out_ff    <= skip_ff;
               was_skipped_ff <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            ST_READ: begin
               cell_re_ff     <= rd_ok_ff ? $signed(grid_rd_ff[95:48]) : 48'sd0;
               cell_im_ff     <= rd_ok_ff ? $signed(grid_rd_ff[47:0]) : 48'sd0;
               norm_out_ff    <= norm_ff;
               skip_out_ff    <= skip_ff;
               was_skipped_ff <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            ST_MUL_UV: state_ff <= ST_RND;
            ST_RND:    state_ff <= ST_OFF;
            ST_OFF: begin
               if (axis_ff) begin
                  state_ff <= ST_MUL_W;
               end else begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_MUL_UV;
               end
            end
            ST_MUL_W:  state_ff <= ST_PLANE;
            ST_PLANE:  state_ff <= ST_CHECK;
            ST_CHECK: begin
               if (off_grid) begin
                  skip_ff        <= skip_inc;
                  cell_re_ff     <= '0;
                  cell_im_ff     <= '0;
                  norm_out_ff    <= norm_ff;
                  skip_out_ff    <= skip_inc;
                  was_skipped_ff <= 1'b1;
                  state_ff       <= ST_IDLE;
               end else begin
                  j_ff     <= -$signed({1'b0, s_ff});
                  k_ff     <= -$signed({1'b0, s_ff});
                  tsum_ff  <= '0;
                  state_ff <= ST_TAPS;
               end
            end
            ST_TAPS: begin
               if (k_ff == $signed({1'b0, s_ff})) begin
                  k_ff <= -$signed({1'b0, s_ff});
                  j_ff <= j_ff + 5'sd1;
                  if (j_ff == $signed({1'b0, s_ff})) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  k_ff <= k_ff + 5'sd1;
               end
            end
            ST_DRAIN: begin
               if (!p1_valid_ff && !p2_valid_ff) begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               norm_ff        <= norm_in;
               cell_re_ff     <= '0;
               cell_im_ff     <= '0;
               norm_out_ff    <= norm_in;
               skip_out_ff    <= skip_ff;
               was_skipped_ff <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_re       = cell_re_ff;
   assign rsp_cell_im       = cell_im_ff;
   assign rsp_norm_sum      = norm_out_ff;
   assign rsp_skipped_count = skip_out_ff;
   assign rsp_was_skipped   = was_skipped_ff;

   // A grid write-back never overlaps the clearing sweep.
   assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> state_ff != ST_CLEAR)
      else $error("tap write-back during grid clear");

   // Every tap in flight was issued by the footprint walk.
   assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> $past(state_ff) == ST_TAPS)
      else $error("tap stage valid without issue");

   // A result is only given once the pipeline has drained.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !p1_valid_ff && !p2_valid_ff)
      else $error("result while taps are still in flight");

   // The skip count only moves with a skipped result.
   assert property (@(posedge clock) disable iff (reset)
      skip_ff != $past(skip_ff) |-> rsp_valid_ff && was_skipped_ff)
      else $error("skip count changed without a skipped item");

endmodule
